FILE: sv/clsrng_pkg.sv
package clsrng_pkg;

    localparam int TABLE_SIZE_DEF = 32;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic [31:0] MOD_ONE  = 32'd2147483563;
    localparam logic [31:0] MOD_TWO  = 32'd2147483399;
    localparam logic [15:0] MUL_ONE  = 16'd40014;
    localparam logic [15:0] MUL_TWO  = 16'd40692;
    localparam logic [30:0] WRAP_ADD = 31'd2147483562;

    localparam logic [30:0] GEN_ONE_RESET = 31'd1;
    localparam logic [30:0] GEN_TWO_RESET = 31'd123456789;

    // Both moduli sit just below 2^31, so 2^31 folds back as a small constant.
    localparam logic [7:0] FOLD_ONE = 8'((33'd1 << 31) - 33'(MOD_ONE));
    localparam logic [7:0] FOLD_TWO = 8'((33'd1 << 31) - 33'(MOD_TWO));

    typedef struct packed {
        logic load_seed;   // load both generators from the seed
        logic mul_en;      // capture the generator and slot products
        logic warm_step;   // advance generator one by one warm-up step
        logic warm_write;  // write the warm-up value into the table
        logic warm_last;   // last warm-up step: copy the value to last_output
        logic draw_red;    // reduce both generators, start slot correction
        logic draw_slot;   // finish the slot index and read the table
        logic draw_out;    // form the result, refill the slot
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Reduces a 31 x 16 bit product modulo 2^31 - fold. The folded sum stays
    // below twice the modulus, so one conditional subtract finishes the job.
    function automatic logic [30:0] mod_reduce(input logic [46:0] prod,
                                               input logic [31:0] mod_val,
                                               input logic [7:0]  fold);
        logic [31:0] sum;
        sum = {1'b0, prod[30:0]} + 32'(prod[46:31]) * 32'(fold);
        if (sum >= mod_val) begin
            sum = sum - mod_val;
        end
        return sum[30:0];
    endfunction

endpackage

FILE: sv/clsrng_ctrl.sv
module clsrng_ctrl #(
    parameter int TABLE_SIZE = clsrng_pkg::TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  clsrng_pkg::status_t           status,
    output clsrng_pkg::cmd_t              cmd,
    output logic [$clog2(TABLE_SIZE)-1:0] warm_idx
);

    localparam int CW = $clog2(TABLE_SIZE + 8);
    localparam int IW = $clog2(TABLE_SIZE);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WARM_MUL = 3'd1;
    localparam logic [2:0] ST_WARM_RED = 3'd2;
    localparam logic [2:0] ST_DRAW_MUL = 3'd3;
    localparam logic [2:0] ST_DRAW_RED = 3'd4;
    localparam logic [2:0] ST_DRAW_SLT = 3'd5;
    localparam logic [2:0] ST_DRAW_OUT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign warm_idx = count_reg[IW-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == clsrng_pkg::OP_RESEED) begin
                        cmd.load_seed = 1'b1;
                        count_next    = CW'(TABLE_SIZE + 7);
                        state_next    = ST_WARM_MUL;
                    end else begin
                        cmd.mul_en = 1'b1;
                        state_next = ST_DRAW_RED;
                    end
                end
            end
            ST_WARM_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED: begin
                cmd.warm_step  = 1'b1;
                cmd.warm_write = (32'(count_reg) < 32'(TABLE_SIZE));
                if (count_reg == '0) begin
                    cmd.warm_last = 1'b1;
                    state_next    = ST_DRAW_MUL;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_WARM_MUL;
                end
            end
            ST_DRAW_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED: begin
                cmd.draw_red = 1'b1;
                state_next   = ST_DRAW_SLT;
            end
            ST_DRAW_SLT: begin
                cmd.draw_slot = 1'b1;
                state_next    = ST_DRAW_OUT;
            end
            ST_DRAW_OUT: begin
                // Hold here while the previous word still sits in the output register.
                if (status.out_free) begin
                    cmd.draw_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/clsrng_datapath.sv
module clsrng_datapath #(
    parameter int TABLE_SIZE = clsrng_pkg::TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [30:0]                   s_seed,
    input  clsrng_pkg::cmd_t              cmd,
    input  logic [$clog2(TABLE_SIZE)-1:0] warm_idx,
    output clsrng_pkg::status_t           status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [30:0]                   m_value
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [31:0] SLOT_DIV =
        32'(64'd1 + (64'(clsrng_pkg::MOD_ONE) - 64'd1) / 64'(TABLE_SIZE));
    // Reciprocal scaled by 2^32; the estimate it gives is low by at most one.
    localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / 64'(SLOT_DIV));
    localparam int          RECIP_W = $clog2(64'(RECIP) + 64'd1);
    localparam int          QW      = RECIP_W - 1;
    localparam int          PW      = 31 + RECIP_W;

    logic [30:0]         first_gen_reg, second_gen_reg, last_output_reg;
    logic [46:0]         prod1_reg, prod2_reg;
    logic [PW-1:0]       qprod_reg;
    logic [QW-1:0]       q0_reg;
    logic [31:0]         qd_reg;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [30:0]         rd_data_reg;
    logic                rd_valid_reg;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [30:0]         table_mem [TABLE_SIZE];
    logic                m_valid_reg;
    logic [30:0]         m_value_reg, value_next;

    logic [30:0]   red1, red2, seed_val, slot_word, wr_data;
    logic [QW-1:0] q0;
    logic [31:0]   rem;
    logic [QW:0]   q_full;
    logic [32:0]   diff;
    logic          wr_en;
    logic [IW-1:0] wr_idx;

    assign red1     = clsrng_pkg::mod_reduce(prod1_reg, clsrng_pkg::MOD_ONE,
                                             clsrng_pkg::FOLD_ONE);
    assign red2     = clsrng_pkg::mod_reduce(prod2_reg, clsrng_pkg::MOD_TWO,
                                             clsrng_pkg::FOLD_TWO);
    assign seed_val = (s_seed == '0) ? 31'd1 : s_seed;
    assign q0       = qprod_reg[PW-1:32];

    always_comb begin
        rem    = {1'b0, last_output_reg} - qd_reg;
        q_full = (QW+1)'(q0_reg) + (QW+1)'(rem >= SLOT_DIV);
        if (32'(q_full) >= 32'(TABLE_SIZE)) begin
            slot_next = IW'(TABLE_SIZE - 1);
        end else begin
            slot_next = q_full[IW-1:0];
        end
    end

    // A slot never written since reset reads as zero.
    assign slot_word = rd_valid_reg ? rd_data_reg : '0;

    always_comb begin
        diff = {2'b00, slot_word} - {2'b00, second_gen_reg};
        if (diff[32] || (diff == '0)) begin
            diff = diff + 33'(clsrng_pkg::WRAP_ADD);
        end
        value_next = diff[30:0];
    end

    assign wr_en   = cmd.warm_write || cmd.draw_out;
    assign wr_idx  = cmd.warm_write ? warm_idx : slot_reg;
    assign wr_data = cmd.warm_write ? red1 : first_gen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_gen_reg   <= clsrng_pkg::GEN_ONE_RESET;
            second_gen_reg  <= clsrng_pkg::GEN_TWO_RESET;
            last_output_reg <= '0;
        end else begin
            if (cmd.load_seed) begin
                first_gen_reg  <= seed_val;
                second_gen_reg <= seed_val;
            end
            if (cmd.warm_step || cmd.draw_red) begin
                first_gen_reg <= red1;
            end
            if (cmd.draw_red) begin
                second_gen_reg <= red2;
            end
            if (cmd.warm_last) begin
                last_output_reg <= red1;
            end else if (cmd.draw_out) begin
                last_output_reg <= value_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod1_reg <= 47'(first_gen_reg) * 47'(clsrng_pkg::MUL_ONE);
            prod2_reg <= 47'(second_gen_reg) * 47'(clsrng_pkg::MUL_TWO);
            qprod_reg <= PW'(last_output_reg) * PW'(RECIP);
        end
        if (cmd.draw_red) begin
            q0_reg <= q0;
            qd_reg <= 32'(q0) * SLOT_DIV;
        end
        if (cmd.draw_slot) begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_idx] <= wr_data;
        end
        if (cmd.draw_slot) begin
            rd_data_reg <= table_mem[slot_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.draw_slot) begin
                rd_valid_reg <= valid_reg[slot_next];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.draw_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.draw_out) begin
            m_value_reg <= value_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_value         = m_value_reg;

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_slot |=> (32'(slot_reg) < 32'(TABLE_SIZE)))
        else $error("table slot index out of range");

    a_gens_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_red |=> ((32'(first_gen_reg) < clsrng_pkg::MOD_ONE)
                          && (32'(second_gen_reg) < clsrng_pkg::MOD_TWO)))
        else $error("generator state not reduced below its modulus");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_value != '0) && (m_value <= clsrng_pkg::WRAP_ADD)))
        else $error("output word out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_out |-> (!m_valid_reg || m_ready))
        else $error("pending output word overwritten");

endmodule

FILE: sv/combined_lcg_shuffle_rng_core.sv
// Combined two-generator random source with a shuffle table. A draw word
// (op = 0) passes through the multiply register, the modular fold, the slot
// index correction with the registered table read, and forming the result
// while the slot is refilled. The next word is taken in the cycle after the
// result is loaded, so a new word is not accepted while a draw is in flight.
// A reseed word (op = 1) adds a load of both generators from the seed and a
// warm-up, since generator one is advanced serially through its multiply and
// fold to fill the table, and then runs a normal draw. The result waits in an
// output register; a new result is not formed until the previous word is
// taken. After reset the table reads as zeros and no clearing pass is needed.
module combined_lcg_shuffle_rng_core #(
    parameter int TABLE_SIZE = clsrng_pkg::TABLE_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [30:0] s_seed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_value
);

    clsrng_pkg::cmd_t              cmd;
    clsrng_pkg::status_t           status;
    logic [$clog2(TABLE_SIZE)-1:0] warm_idx;

    clsrng_ctrl #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .status   (status),
        .cmd      (cmd),
        .warm_idx (warm_idx)
    );

    clsrng_datapath #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_seed   (s_seed),
        .cmd      (cmd),
        .warm_idx (warm_idx),
        .status   (status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value)
    );

endmodule
